### sv/sspt_pkg.sv
// sspt_pkg: widths, payload structs and pipeline stage records for the swept sphere pair test
// no dependencies; imported by swept_sphere_pair_test_top
`timescale 1ns / 1ps
package sspt_pkg;

  localparam int COORD_BITS     = 21;
  localparam int TIME_FRAC_BITS = 16;
  localparam int TAU_BITS       = 20;
  localparam int RAD_BITS       = 20;
  localparam int VEC_BITS       = 63;

  // derived widths
  localparam int INT_BITS = TAU_BITS - TIME_FRAC_BITS;  // integer bits of the time format
  localparam int DW   = COORD_BITS + 1;                 // difference component
  localparam int PW   = 2 * DW;                         // component product
  localparam int SQW  = PW + 2;                         // sum of three squares
  localparam int RVW  = PW + 2;                         // signed dot product
  localparam int RW   = RAD_BITS + 1;                   // radius sum
  localparam int RSW  = 2 * RW;                         // squared radius sum
  localparam int DVW  = SQW + INT_BITS;                 // scaled divisor
  localparam int TPW  = TAU_BITS + 1 + DW;              // time times velocity
  localparam int DDW  = TPW - TIME_FRAC_BITS + 1;       // displaced component
  localparam int DSW  = 2 * DDW;                        // displaced square
  localparam int DDSW = DSW + 2;                        // displaced distance squared
  localparam int NDIV = TAU_BITS;                       // one quotient bit per stage

  typedef struct packed {
    logic [VEC_BITS-1:0] pos_a;
    logic [VEC_BITS-1:0] vel_a;
    logic [RAD_BITS-1:0] radius_a;
    logic [VEC_BITS-1:0] pos_b;
    logic [VEC_BITS-1:0] vel_b;
    logic [RAD_BITS-1:0] radius_b;
    logic                sticky_a;
    logic                sticky_b;
    logic                active_a;
    logic                active_b;
  } pair_t;

  typedef struct packed {
    logic hit;
    logic hit_at_start;
    logic count_a;
    logic count_b;
  } result_t;

  // flags carried down the pipe
  typedef struct packed {
    logic aa;
    logic ab;
    logic start;
    logic later;
  } flags_t;

  typedef struct packed {
    logic [2:0][DW-1:0] r;
    logic [2:0][DW-1:0] v;
    logic [RW-1:0]      reach;
    logic               elig;
    logic               aa;
    logic               ab;
  } s1_t;

  typedef struct packed {
    logic [2:0][PW-1:0] rr_p;
    logic [2:0][PW-1:0] vv_p;
    logic [2:0][PW-1:0] rv_p;
    logic [RSW-1:0]     reach_sq;
    logic [2:0][DW-1:0] r;
    logic [2:0][DW-1:0] v;
    logic               elig;
    logic               aa;
    logic               ab;
  } s2_t;

  typedef struct packed {
    logic [SQW-1:0]     rr;
    logic [SQW-1:0]     vv;
    logic [RVW-1:0]     rv;
    logic [RSW-1:0]     reach_sq;
    logic [2:0][DW-1:0] r;
    logic [2:0][DW-1:0] v;
    logic               elig;
    logic               aa;
    logic               ab;
  } s3_t;

  typedef struct packed {
    logic [DVW-1:0]      rem;
    logic [DVW-1:0]      dv;
    logic [TAU_BITS-1:0] q;
    logic                sat;
    logic [RSW-1:0]      reach_sq;
    logic [2:0][DW-1:0]  r;
    logic [2:0][DW-1:0]  v;
    flags_t              fl;
  } div_t;

  typedef struct packed {
    logic [TAU_BITS-1:0] t;
    logic [RSW-1:0]      reach_sq;
    logic [2:0][DW-1:0]  r;
    logic [2:0][DW-1:0]  v;
    flags_t              fl;
  } st_t;

  typedef struct packed {
    logic [2:0][TPW-1:0] p;
    logic [RSW-1:0]      reach_sq;
    logic [2:0][DW-1:0]  r;
    flags_t              fl;
  } sm_t;

  typedef struct packed {
    logic [2:0][DDW-1:0] d;
    logic [RSW-1:0]      reach_sq;
    flags_t              fl;
  } sf_t;

  typedef struct packed {
    logic [2:0][DSW-1:0] dsq;
    logic [RSW-1:0]      reach_sq;
    flags_t              fl;
  } ss_t;

  typedef struct packed {
    logic [DDSW-1:0] dd;
    logic [RSW-1:0]  reach_sq;
    flags_t          fl;
  } sc_t;

endpackage

### sv/swept_sphere_pair_test_top.sv
// swept_sphere_pair_test_top: streaming moving-sphere contact test for one particle pair
// depends on sspt_pkg (widths, payload and stage structs)
// throughput: one pair per cycle; each stage holds its item only while the next one is full
// the closest-approach divide is a 20-stage restoring divider, one quotient bit per stage
// reset (rst, synchronous): all stage valid bits clear, tau_window returns to zero
`timescale 1ns / 1ps
module swept_sphere_pair_test_top
  import sspt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                pair_valid,
  output logic                pair_ready,
  input  pair_t               pair,
  output logic                result_valid,
  input  logic                result_ready,
  output result_t             result,
  input  logic                tau_we,
  input  logic [TAU_BITS-1:0] tau_wdata
);

  // stage positions in the valid chain
  localparam int S1   = 0;
  localparam int S2   = 1;
  localparam int S3   = 2;
  localparam int S4   = 3;
  localparam int DIV0 = 4;
  localparam int ST   = DIV0 + NDIV;
  localparam int SM   = ST + 1;
  localparam int SF   = ST + 2;
  localparam int SS   = ST + 3;
  localparam int SC   = ST + 4;
  localparam int SO   = ST + 5;
  localparam int NSTG = SO + 1;

  logic [TAU_BITS-1:0] tau_window;
  logic [NSTG-1:0]     vld;
  logic [NSTG-1:0]     adv;

  s1_t     s1, s1_next;
  s2_t     s2, s2_next;
  s3_t     s3, s3_next;
  div_t    s4, s4_next;
  div_t    dstg [NDIV];
  div_t    dstg_next [NDIV];
  st_t     st, st_next;
  sm_t     sm, sm_next;
  sf_t     sf, sf_next;
  ss_t     ss, ss_next;
  sc_t     sc, sc_next;
  result_t res_next;

  // look-ahead window register
  always_ff @(posedge clk) begin
    if (rst) begin
      tau_window <= '0;
    end else if (tau_we) begin
      tau_window <= tau_wdata;
    end
  end

  // a stage may load when it is empty or its content moves on this cycle
  always_comb begin
    adv[SO] = !vld[SO] || result_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign pair_ready   = adv[S1];
  assign result_valid = vld[SO];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[S1]) begin
        vld[S1] <= pair_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1: component differences, radius sum, eligibility
  always_comb begin
    logic [COORD_BITS-1:0] pa, pb, va, vb;
    s1_next = '0;
    for (int k = 0; k < 3; k++) begin
      pa = pair.pos_a[k*COORD_BITS +: COORD_BITS];
      pb = pair.pos_b[k*COORD_BITS +: COORD_BITS];
      va = pair.vel_a[k*COORD_BITS +: COORD_BITS];
      vb = pair.vel_b[k*COORD_BITS +: COORD_BITS];
      s1_next.r[k] = $signed({pa[COORD_BITS-1], pa}) - $signed({pb[COORD_BITS-1], pb});
      s1_next.v[k] = $signed({va[COORD_BITS-1], va}) - $signed({vb[COORD_BITS-1], vb});
    end
    s1_next.reach = {1'b0, pair.radius_a} + {1'b0, pair.radius_b};
    s1_next.elig  = pair.sticky_a && pair.sticky_b && (pair.active_a || pair.active_b);
    s1_next.aa    = pair.active_a;
    s1_next.ab    = pair.active_b;
  end

  // stage 2: products
  always_comb begin
    s2_next = '0;
    for (int k = 0; k < 3; k++) begin
      s2_next.rr_p[k] = PW'($signed(s1.r[k]) * $signed(s1.r[k]));
      s2_next.vv_p[k] = PW'($signed(s1.v[k]) * $signed(s1.v[k]));
      s2_next.rv_p[k] = PW'($signed(s1.r[k]) * $signed(s1.v[k]));
    end
    s2_next.reach_sq = RSW'(s1.reach * s1.reach);
    s2_next.r        = s1.r;
    s2_next.v        = s1.v;
    s2_next.elig     = s1.elig;
    s2_next.aa       = s1.aa;
    s2_next.ab       = s1.ab;
  end

  // stage 3: dot products
  always_comb begin
    s3_next    = '0;
    s3_next.rr = SQW'(s2.rr_p[0]) + SQW'(s2.rr_p[1]) + SQW'(s2.rr_p[2]);
    s3_next.vv = SQW'(s2.vv_p[0]) + SQW'(s2.vv_p[1]) + SQW'(s2.vv_p[2]);
    s3_next.rv = $signed({{2{s2.rv_p[0][PW-1]}}, s2.rv_p[0]})
               + $signed({{2{s2.rv_p[1][PW-1]}}, s2.rv_p[1]})
               + $signed({{2{s2.rv_p[2][PW-1]}}, s2.rv_p[2]});
    s3_next.reach_sq = s2.reach_sq;
    s3_next.r        = s2.r;
    s3_next.v        = s2.v;
    s3_next.elig     = s2.elig;
    s3_next.aa       = s2.aa;
    s3_next.ab       = s2.ab;
  end

  // stage 4: present overlap, later-test gating, divider set-up
  always_comb begin
    logic [RVW-1:0] n;
    logic           start, converging;
    n          = RVW'(-$signed(s3.rv));
    start      = s3.elig && (s3.rr < SQW'(s3.reach_sq));
    converging = s3.rv[RVW-1] || (s3.rv == '0);
    s4_next          = '0;
    s4_next.dv       = {s3.vv, {INT_BITS{1'b0}}};
    s4_next.rem      = DVW'(n);
    s4_next.sat      = DVW'(n) >= {s3.vv, {INT_BITS{1'b0}}};
    s4_next.reach_sq = s3.reach_sq;
    s4_next.r        = s3.r;
    s4_next.v        = s3.v;
    s4_next.fl.aa    = s3.aa;
    s4_next.fl.ab    = s3.ab;
    s4_next.fl.start = start;
    s4_next.fl.later = s3.elig && !start && (tau_window != '0) && converging
                       && (s3.vv != '0);
  end

  // divider stages: one restoring step each; the remainder stays below the divisor whenever it starts below it
  always_comb begin
    div_t            src;
    logic [DVW:0]    rem2;
    logic            qbit;
    for (int j = 0; j < NDIV; j++) begin
      src  = (j == 0) ? s4 : dstg[j-1];
      rem2 = {src.rem, 1'b0};
      qbit = rem2 >= {1'b0, src.dv};
      dstg_next[j]     = src;
      dstg_next[j].rem = qbit ? DVW'(rem2 - {1'b0, src.dv}) : DVW'(rem2);
      dstg_next[j].q   = {src.q[TAU_BITS-2:0], qbit};
    end
  end

  // clip the approach time to the window
  always_comb begin
    div_t last;
    last             = dstg[NDIV-1];
    st_next.t        = (last.sat || last.q > tau_window) ? tau_window : last.q;
    st_next.reach_sq = last.reach_sq;
    st_next.r        = last.r;
    st_next.v        = last.v;
    st_next.fl       = last.fl;
  end

  // time times relative velocity
  always_comb begin
    sm_next = '0;
    for (int k = 0; k < 3; k++) begin
      sm_next.p[k] = TPW'($signed({1'b0, st.t}) * $signed(st.v[k]));
    end
    sm_next.reach_sq = st.reach_sq;
    sm_next.r        = st.r;
    sm_next.fl       = st.fl;
  end

  // floor scaling back to position units, then displaced separation
  always_comb begin
    logic [TPW-TIME_FRAC_BITS-1:0] sh;
    sf_next = '0;
    for (int k = 0; k < 3; k++) begin
      sh = sm.p[k][TPW-1:TIME_FRAC_BITS];
      sf_next.d[k] = $signed({sh[TPW-TIME_FRAC_BITS-1], sh})
                   + $signed({{(DDW-DW){sm.r[k][DW-1]}}, sm.r[k]});
    end
    sf_next.reach_sq = sm.reach_sq;
    sf_next.fl       = sm.fl;
  end

  always_comb begin
    ss_next = '0;
    for (int k = 0; k < 3; k++) begin
      ss_next.dsq[k] = DSW'($signed(sf.d[k]) * $signed(sf.d[k]));
    end
    ss_next.reach_sq = sf.reach_sq;
    ss_next.fl       = sf.fl;
  end

  always_comb begin
    sc_next.dd       = DDSW'(ss.dsq[0]) + DDSW'(ss.dsq[1]) + DDSW'(ss.dsq[2]);
    sc_next.reach_sq = ss.reach_sq;
    sc_next.fl       = ss.fl;
  end

  // final decision, held in the output register
  always_comb begin
    logic h;
    h                     = sc.fl.start || (sc.fl.later && sc.dd < DDSW'(sc.reach_sq));
    res_next.hit          = h;
    res_next.hit_at_start = sc.fl.start;
    res_next.count_a      = h && sc.fl.aa;
    res_next.count_b      = h && sc.fl.ab;
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (adv[S1]) begin
      s1 <= s1_next;
    end
    if (adv[S2]) begin
      s2 <= s2_next;
    end
    if (adv[S3]) begin
      s3 <= s3_next;
    end
    if (adv[S4]) begin
      s4 <= s4_next;
    end
    for (int j = 0; j < NDIV; j++) begin
      if (adv[DIV0+j]) begin
        dstg[j] <= dstg_next[j];
      end
    end
    if (adv[ST]) begin
      st <= st_next;
    end
    if (adv[SM]) begin
      sm <= sm_next;
    end
    if (adv[SF]) begin
      sf <= sf_next;
    end
    if (adv[SS]) begin
      ss <= ss_next;
    end
    if (adv[SC]) begin
      sc <= sc_next;
    end
    if (adv[SO]) begin
      result <= res_next;
    end
  end

  // checks
  a_count_needs_hit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((!result.count_a && !result.count_b) || result.hit))
    else $error("partner count raised without a hit");

  a_start_is_hit: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.hit_at_start |-> result.hit)
    else $error("start overlap not reported as hit");

  a_zero_window: assert property (@(posedge clk) disable iff (rst)
    result_valid && (tau_window == '0) |-> (result.hit == result.hit_at_start))
    else $error("later hit with zero window");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result offered straight after reset");

endmodule

### tb/swept_sphere_pair_test_top_tb.sv
// swept_sphere_pair_test_top_tb: self-checking bench for the swept sphere pair contact test
// depends on sspt_pkg and swept_sphere_pair_test_top; predicts each result in integer arithmetic
`timescale 1ns / 1ps
module swept_sphere_pair_test_top_tb;
  import sspt_pkg::*;

  localparam int LATENCY = 30;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pair_valid = 1'b0;
  logic pair_ready;
  pair_t pair = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic tau_we = 1'b0;
  logic [TAU_BITS-1:0] tau_wdata = '0;

  swept_sphere_pair_test_top dut (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_ready(pair_ready), .pair(pair),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .tau_we(tau_we), .tau_wdata(tau_wdata)
  );

  always #1 clk = ~clk;

  // pairs waiting for the driver; each is checked against the window in force when it is accepted
  pair_t pending_pairs[$];
  result_t expected_contacts[$];
  logic [TAU_BITS-1:0] window_now = '0;  // predictor's copy of tau_window
  int errors = 0;
  longint cycles = 0;

  // sender pacing and the pressure controls
  int burst_left = 0;
  int gap_left = 0;
  bit hold_sender = 1'b0;
  int stall_left = 0;
  bit long_stall_req = 1'b0;

  function automatic longint signed coord(logic [VEC_BITS-1:0] packed_vec, int k);
    logic [COORD_BITS-1:0] raw;
    raw = packed_vec[k*COORD_BITS +: COORD_BITS];
    return longint'(signed'(raw));
  endfunction

  // floor division by 2^F
  function automatic longint signed floor_frac(longint signed x);
    return x >>> TIME_FRAC_BITS;
  endfunction

  function automatic result_t predict_contact(pair_t p, logic [TAU_BITS-1:0] tau);
    result_t res;
    longint signed r[3], v[3], rv, d;
    longint unsigned vv, rr, dd, reach_sq, ip, rem, frac, t;
    bit start, hit;
    res = '0;
    start = 0;
    hit = 0;
    reach_sq = (longint'(p.radius_a) + longint'(p.radius_b));
    reach_sq = reach_sq * reach_sq;
    if (p.sticky_a && p.sticky_b && (p.active_a || p.active_b)) begin
      rr = 0; rv = 0; vv = 0;
      for (int k = 0; k < 3; k++) begin
        r[k] = coord(p.pos_a, k) - coord(p.pos_b, k);
        v[k] = coord(p.vel_a, k) - coord(p.vel_b, k);
        rr += r[k] * r[k];
        rv += r[k] * v[k];
        vv += v[k] * v[k];
      end
      if (rr < reach_sq) begin
        start = 1;
        hit = 1;
      end else if (tau != 0 && rv <= 0 && vv != 0) begin
        ip = longint'(-rv) / vv;
        rem = longint'(-rv) % vv;
        if (ip >= (64'd1 << TAU_BITS)) begin
          t = tau;
        end else begin
          frac = 0;
          for (int k = 0; k < TIME_FRAC_BITS; k++) begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= vv) begin
              rem -= vv;
              frac |= 1;
            end
          end
          t = (ip << TIME_FRAC_BITS) | frac;
          if (t > tau) t = tau;
        end
        dd = 0;
        for (int k = 0; k < 3; k++) begin
          d = r[k] + floor_frac(longint'(t) * v[k]);
          dd += d * d;
        end
        hit = dd < reach_sq;
      end
    end
    res.hit = hit;
    res.hit_at_start = start;
    res.count_a = hit && p.active_a;
    res.count_b = hit && p.active_b;
    return res;
  endfunction

  // driver: bursts with random gaps; valid held until the transaction is taken
  always @(posedge clk) begin
    if (!rst) begin
      if (pair_valid && pair_ready) begin
        expected_contacts.push_back(predict_contact(pair, window_now));
      end
      if (!pair_valid || pair_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          pair_valid <= 1'b0;
        end else if (pending_pairs.size() > 0 && !hold_sender) begin
          pair <= pending_pairs.pop_front();
          pair_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          pair_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: own stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (long_stall_req && stall_left == 0) begin
      stall_left <= 200;
      result_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_ready <= (stall_left == 1);
    end else begin
      case ((cycles / 500) % 3)
        0: result_ready <= 1'b1;
        1: result_ready <= ($urandom_range(0, 3) != 0);
        default: result_ready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && result_valid && result_ready) begin
      if (expected_contacts.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        result_t exp_res;
        exp_res = expected_contacts.pop_front();
        if (result.hit !== exp_res.hit) begin
          $error("hit: expected %0b actual %0b", exp_res.hit, result.hit); errors++;
        end
        if (result.hit_at_start !== exp_res.hit_at_start) begin
          $error("hit_at_start: expected %0b actual %0b", exp_res.hit_at_start,
                 result.hit_at_start); errors++;
        end
        if (result.count_a !== exp_res.count_a) begin
          $error("count_a: expected %0b actual %0b", exp_res.count_a, result.count_a);
          errors++;
        end
        if (result.count_b !== exp_res.count_b) begin
          $error("count_b: expected %0b actual %0b", exp_res.count_b, result.count_b);
          errors++;
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [COORD_BITS-1:0] rand_coord(int mode);
    case (mode)
      0: return COORD_BITS'($urandom);
      1: return COORD_BITS'($signed($urandom_range(0, 400)) - 200);
      default: return COORD_BITS'($signed($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  function automatic logic [VEC_BITS-1:0] rand_vec(int mode);
    logic [VEC_BITS-1:0] vec;
    for (int k = 0; k < 3; k++) vec[k*COORD_BITS +: COORD_BITS] = rand_coord(mode);
    return vec;
  endfunction

  // random pair, mostly eligible and mostly on a closing course near contact
  function automatic pair_t random_pair();
    pair_t p;
    int mode;
    logic [COORD_BITS-1:0] c;
    mode = $urandom_range(0, 9);
    p.pos_a = rand_vec(mode < 2 ? 0 : 2);
    p.vel_a = rand_vec(mode < 2 ? 0 : 1);
    p.vel_b = rand_vec(mode < 2 ? 0 : 1);
    if (mode >= 4) begin
      // b placed ahead along the relative velocity so that the approach is real
      for (int k = 0; k < 3; k++) begin
        c = p.pos_a[k*COORD_BITS +: COORD_BITS];
        p.pos_b[k*COORD_BITS +: COORD_BITS] = c + COORD_BITS'(($signed(
          p.vel_a[k*COORD_BITS +: COORD_BITS]) - $signed(p.vel_b[k*COORD_BITS +: COORD_BITS]))
          * $urandom_range(0, 20)) + rand_coord(1);
      end
    end else begin
      p.pos_b = rand_vec(mode < 2 ? 0 : 2);
    end
    if (mode == 9) p.vel_b = p.vel_a;
    p.radius_a = (mode < 2) ? RAD_BITS'($urandom) : RAD_BITS'($urandom_range(0, 3000));
    p.radius_b = (mode < 2) ? RAD_BITS'($urandom) : RAD_BITS'($urandom_range(0, 3000));
    p.sticky_a = ($urandom_range(0, 9) != 0);
    p.sticky_b = ($urandom_range(0, 9) != 0);
    p.active_a = $urandom_range(0, 1);
    p.active_b = ($urandom_range(0, 2) != 0);
    // sign bit of the third component randomised again
    p.pos_a[VEC_BITS-1] = $urandom_range(0, 1);
    p.vel_b[VEC_BITS-1] = $urandom_range(0, 1);
    return p;
  endfunction

  task automatic wait_drained();
    while (pending_pairs.size() > 0 || pair_valid || expected_contacts.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_window(logic [TAU_BITS-1:0] value);
    tau_we <= 1'b1;
    tau_wdata <= value;
    @(posedge clk);
    tau_we <= 1'b0;
    window_now = value;
  endtask

  initial begin
    pair_t p;
    logic [TAU_BITS-1:0] windows[6];
    windows = '{20'hFFFFF, 20'h10000, 20'h00001, 20'h40000, 20'h08000, 20'h00000};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: window at reset value (present overlap only)
    p = '0; p.sticky_a = 1; p.sticky_b = 1; p.active_a = 1; p.radius_a = 5;
    pending_pairs.push_back(p);                          // touching at start
    p.radius_a = '1; p.radius_b = '1; p.active_b = 1;
    p.pos_a = {3{21'h0FFFFF}}; p.pos_b = {3{21'h100000}};
    pending_pairs.push_back(p);                          // extreme spread, largest radii
    p.radius_a = 0; p.radius_b = 0;
    pending_pairs.push_back(p);                          // zero reach
    wait_drained();

    write_window(20'hFFFFF);
    p = '0; p.sticky_a = 1; p.sticky_b = 1; p.active_b = 1;
    p.pos_a = 63'd1000; p.vel_a = {21'd0, 21'd0, 21'h1FFFF6};
    p.radius_a = 10; p.radius_b = 10;
    pending_pairs.push_back(p);                          // closing, hits later
    p.vel_a = 63'd10;
    pending_pairs.push_back(p);                          // diverging
    p.vel_a = 0;
    pending_pairs.push_back(p);                          // no relative motion
    p.vel_a = {21'd0, 21'd0, 21'h1FFFFF}; p.pos_a = 63'd900000;
    pending_pairs.push_back(p);                          // approach beyond the window
    p.vel_a = {3{21'h100000}}; p.vel_b = {3{21'h0FFFFF}};
    p.pos_a = {3{21'h0FFFFF}}; p.pos_b = {3{21'h100000}};
    pending_pairs.push_back(p);                          // extreme velocities
    for (int f = 0; f < 16; f++) begin
      p = random_pair();
      p.sticky_a = f[0]; p.sticky_b = f[1]; p.active_a = f[2]; p.active_b = f[3];
      pending_pairs.push_back(p);                        // every flag combination
    end
    wait_drained();

    // random phases across window settings
    for (int ph = 0; ph < 6; ph++) begin
      write_window(ph == 2 ? TAU_BITS'($urandom) : windows[ph]);
      for (int i = 0; i < 330; i++) pending_pairs.push_back(random_pair());
      if (ph == 1) begin
        // long receiver hold-off while the sender keeps offering
        while (pending_pairs.size() > 250) @(posedge clk);
        long_stall_req = 1'b1;
        while (stall_left == 0) @(posedge clk);
        long_stall_req = 1'b0;
      end
      if (ph == 3) begin
        // sender pauses until every result has come back
        while (pending_pairs.size() > 150) @(posedge clk);
        hold_sender = 1'b1;
        while (pair_valid || expected_contacts.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
